### sv/rtfs_pkg.sv
package rtfs_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned MASK_W      = 64;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MASK = 2'd1;

    localparam logic [DATA_W-1:0] ONE_FIXED        = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SAT_VALUE        = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] TIME_LIMIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        ACT_EVAL  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CAUSE_CONTINUE = 2'd0,
        CAUSE_TIME     = 2'd1,
        CAUSE_FLIP     = 2'd2,
        CAUSE_CLEAR    = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        t_cause            kind;
        logic [IDX_W-1:0]  idx;
        logic              idx_ok;
        logic              mark;
        logic [DATA_W-1:0] sim_time;
    } t_entry;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        sat_inc = (v == SAT_VALUE) ? SAT_VALUE : v + 1'b1;
    endfunction

endpackage

### sv/rtfs_front.sv
module rtfs_front #(
    parameter int unsigned REACTION_COUNT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rtfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtfs_pkg::MASK_W-1:0]      i_cfg_data,
    input  logic                             i_action,
    input  logic [rtfs_pkg::IDX_W-1:0]       i_reaction_index,
    input  logic [rtfs_pkg::DATA_W-1:0]      i_sim_time,
    input  logic [rtfs_pkg::DATA_W-1:0]      i_switch_quantity,
    output rtfs_pkg::t_entry                 o_entry
);
    import rtfs_pkg::*;

    logic [DATA_W-1:0] r_time_limit;
    logic [MASK_W-1:0] r_switch_mask;
    logic              idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_limit  <= TIME_LIMIT_RESET;
            r_switch_mask <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_TIME_LIMIT) begin
                r_time_limit <= i_cfg_data[DATA_W-1:0];
            end
            if (i_cfg_index == REG_SWITCH_MASK) begin
                r_switch_mask <= i_cfg_data;
            end
        end
    end

    always_comb begin
        idx_ok = ({1'b0, i_reaction_index} < (IDX_W + 1)'(REACTION_COUNT));
        o_entry.idx      = i_reaction_index;
        o_entry.idx_ok   = idx_ok;
        o_entry.mark     = idx_ok & r_switch_mask[i_reaction_index];
        o_entry.sim_time = i_sim_time;
        if (t_action'(i_action) == ACT_CLEAR) begin
            o_entry.kind = CAUSE_CLEAR;
        end else if (i_sim_time >= r_time_limit) begin
            o_entry.kind = CAUSE_TIME;
        end else if (i_switch_quantity >= ONE_FIXED) begin
            o_entry.kind = CAUSE_FLIP;
        end else begin
            o_entry.kind = CAUSE_CONTINUE;
        end
    end

endmodule

### sv/rtfs_queue.sv
module rtfs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rtfs_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output rtfs_pkg::t_entry o_entry,
    output logic             o_empty
);
    import rtfs_pkg::*;

    t_entry              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### sv/rtfs_back.sv
module rtfs_back #(
    parameter int unsigned REACTION_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtfs_pkg::t_entry              i_entry,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_terminate,
    output logic [1:0]                    o_cause,
    output logic [rtfs_pkg::DATA_W-1:0]   o_flip_total,
    output logic [rtfs_pkg::DATA_W-1:0]   o_timeout_total,
    output logic [rtfs_pkg::DATA_W-1:0]   o_mean_flip_time,
    output logic [rtfs_pkg::DATA_W-1:0]   o_reaction_flip_count
);
    import rtfs_pkg::*;

    localparam int unsigned AW = (REACTION_COUNT > 1) ? $clog2(REACTION_COUNT) : 1;

    t_back_state          r_state;
    t_back_state          n_state;
    t_entry               r_item;
    logic [DATA_W-1:0]    r_mem [REACTION_COUNT];
    logic [DATA_W-1:0]    r_rd_data;
    logic                 r_rd_vld;
    logic [REACTION_COUNT-1:0] r_valid_bits;

    logic [DATA_W-1:0]    r_flips;
    logic [DATA_W-1:0]    r_timeouts;
    logic [DATA_W-1:0]    r_mean;
    logic [DATA_W-1:0]    r_n;
    logic                 r_neg;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_bit_cnt;

    logic                 r_out_valid;
    logic                 r_out_term;
    t_cause               r_out_cause;
    logic [DATA_W-1:0]    r_out_flips;
    logic [DATA_W-1:0]    r_out_timeouts;
    logic [DATA_W-1:0]    r_out_mean;
    logic [DATA_W-1:0]    r_out_count;

    logic                 finish;
    logic                 mem_wr;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [DATA_W:0]      trial;
    logic                 ge;
    logic [DATA_W:0]      diff;
    logic [DATA_W-1:0]    n_n;
    logic                 n_neg;
    logic [DATA_W-1:0]    n_mag;
    logic [DATA_W-1:0]    cur_count;
    logic [DATA_W-1:0]    n_count;
    logic [DATA_W-1:0]    n_flips;
    logic [DATA_W-1:0]    n_timeouts;
    logic [DATA_W-1:0]    n_mean;
    logic                 n_term;

    assign rd_addr = i_entry.idx[AW-1:0];
    assign wr_addr = r_item.idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = (r_item.kind == CAUSE_FLIP) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[DATA_W-1]};
        diff  = trial - {1'b0, r_n};
        ge    = (trial >= {1'b0, r_n});
    end

    always_comb begin
        n_n   = sat_inc(r_flips);
        n_neg = (r_item.sim_time < r_mean);
        n_mag = n_neg ? (r_mean - r_item.sim_time) : (r_item.sim_time - r_mean);
    end

    always_comb begin
        cur_count  = (r_item.idx_ok && r_rd_vld) ? r_rd_data : '0;
        n_count    = cur_count;
        n_flips    = r_flips;
        n_timeouts = r_timeouts;
        n_mean     = r_mean;
        n_term     = 1'b0;
        mem_wr     = 1'b0;
        case (r_item.kind)
            CAUSE_CLEAR: begin
                n_flips    = '0;
                n_timeouts = '0;
                n_mean     = '0;
            end
            CAUSE_TIME: begin
                n_timeouts = sat_inc(r_timeouts);
                n_term     = 1'b1;
            end
            CAUSE_FLIP: begin
                n_flips = r_n;
                n_mean  = r_neg ? (r_mean - r_quo) : (r_mean + r_quo);
                n_term  = 1'b1;
                if (r_item.mark) begin
                    n_count = sat_inc(cur_count);
                    mem_wr  = finish;
                end
            end
            default: begin
                n_term = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid_bits <= '0;
            r_flips      <= '0;
            r_timeouts   <= '0;
            r_mean       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_wr) begin
                r_valid_bits[wr_addr] <= 1'b1;
            end
            if (finish) begin
                r_flips    <= n_flips;
                r_timeouts <= n_timeouts;
                r_mean     <= n_mean;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item    <= i_entry;
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= i_entry.idx_ok & r_valid_bits[rd_addr];
        end
        if (mem_wr) begin
            r_mem[wr_addr] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_n       <= n_n;
            r_neg     <= n_neg;
            r_rem     <= '0;
            r_quo     <= n_mag;
            r_bit_cnt <= DIV_CNT_W'(DATA_W - 1);
        end else if (r_state == ST_DIV) begin
            r_rem     <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            r_quo     <= {r_quo[DATA_W-2:0], ge};
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end
        if (finish) begin
            r_out_term     <= n_term;
            r_out_cause    <= r_item.kind;
            r_out_flips    <= n_flips;
            r_out_timeouts <= n_timeouts;
            r_out_mean     <= n_mean;
            r_out_count    <= r_item.idx_ok ? n_count : '0;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_terminate           = r_out_term;
    assign o_cause               = r_out_cause;
    assign o_flip_total          = r_out_flips;
    assign o_timeout_total       = r_out_timeouts;
    assign o_mean_flip_time      = r_out_mean;
    assign o_reaction_flip_count = r_out_count;

endmodule

### sv/run_termination_flip_statistics.sv
// Run termination decider with flip statistics.
// Input channel (i_valid/o_ready) takes one word per simulation event: action,
// reaction index, time and switch quantity, all 16.16 where fractional.
// Output channel (o_valid/i_ready) returns one word per input word, in order:
// terminate, cause, run totals, running mean flip time, reaction flip count.
// Config port: i_cfg_we with i_cfg_index 0 (time limit) or 1 (switching mask),
// which the user must write only while the block is idle; the block does not enforce this.
// The front classifies each word on acceptance and parks it in a two-entry
// queue; the back reads the reaction counter, updates statistics and loads the
// output register.
// In the back, clear, timeout and continue words pass through the idle, prep
// and done states; a flip word also runs the 32-step serial divider of the
// mean update between prep and done.
// Reset clears totals, mean, reaction counter valid bits, queue and output
// valid flag; time limit resets to all ones, mask to zero.
// A stalled receiver holds the result in the output register; the back then
// waits, the queue fills and o_ready drops when it is full.
module run_termination_flip_statistics #(
    parameter int unsigned REACTION_COUNT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rtfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtfs_pkg::MASK_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [rtfs_pkg::IDX_W-1:0]       i_reaction_index,
    input  logic [rtfs_pkg::DATA_W-1:0]      i_sim_time,
    input  logic [rtfs_pkg::DATA_W-1:0]      i_switch_quantity,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_terminate,
    output logic [1:0]                       o_cause,
    output logic [rtfs_pkg::DATA_W-1:0]      o_flip_total,
    output logic [rtfs_pkg::DATA_W-1:0]      o_timeout_total,
    output logic [rtfs_pkg::DATA_W-1:0]      o_mean_flip_time,
    output logic [rtfs_pkg::DATA_W-1:0]      o_reaction_flip_count
);
    import rtfs_pkg::*;

    t_entry front_entry;
    t_entry head_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    assign o_ready = !q_full;

    rtfs_front #(
        .REACTION_COUNT (REACTION_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_reaction_index  (i_reaction_index),
        .i_sim_time        (i_sim_time),
        .i_switch_quantity (i_switch_quantity),
        .o_entry           (front_entry)
    );

    rtfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid & !q_full),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (head_entry),
        .o_empty (q_empty)
    );

    rtfs_back #(
        .REACTION_COUNT (REACTION_COUNT)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_entry               (head_entry),
        .i_empty               (q_empty),
        .o_pop                 (q_pop),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_terminate           (o_terminate),
        .o_cause               (o_cause),
        .o_flip_total          (o_flip_total),
        .o_timeout_total       (o_timeout_total),
        .o_mean_flip_time      (o_mean_flip_time),
        .o_reaction_flip_count (o_reaction_flip_count)
    );

endmodule
